[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that an expression never becomes true outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(expr), msg)

`endif

[hdl/cma_pkg.sv]
// ----------------------------------------------------------------------------
// Current moving average package
// Sizes, scaling constants and types shared by the moving average RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

  localparam int CHANNELS = 16;
  localparam int WINDOW   = 50;

  localparam int CH_W        = 4;
  localparam int RAW_W       = 16;
  localparam int MAG_W       = 15;
  localparam int SAMPLE_W    = 10;
  localparam int AVG_W       = 10;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam int MAX_SAMPLE = 608;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int DEPTH    = CHANNELS * WINDOW;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SUM_W    = $clog2(WINDOW * MAX_SAMPLE + 1);
  localparam int Q_W      = 10;

  // Scaling by reciprocal multiplication, exact for every 15-bit magnitude.
  localparam int SCALE_MUL_W  = 24;
  localparam int SCALE_PROD_W = MAG_W + SCALE_MUL_W;
  localparam logic [SCALE_MUL_W-1:0] SCALE_MUL_020 = 24'd5243;
  localparam int SCALE_SHIFT_020 = 19;
  localparam logic [SCALE_MUL_W-1:0] SCALE_MUL_010 = 24'd9970467;
  localparam int SCALE_SHIFT_010 = 29;

  // Division of the window sum by the window length.
  localparam int SUM_RECIP_W = 32;
  localparam int SUM_SHIFT   = 32;
  localparam longint unsigned SUM_RECIP_L =
    ((64'd1 << SUM_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [SUM_RECIP_W-1:0] SUM_RECIP = SUM_RECIP_W'(SUM_RECIP_L);
  localparam int SUM_PROD_W = SUM_W + SUM_RECIP_W;

  // Multiplication by 1.09 with flooring.
  localparam int AVG_MUL_W  = 25;
  localparam logic [AVG_MUL_W-1:0] AVG_MUL = 25'd18287257;
  localparam int AVG_SHIFT  = 24;
  localparam int AVG_PROD_W = Q_W + AVG_MUL_W;

  typedef enum logic {
    SHUNT_020 = 1'b0,
    SHUNT_010 = 1'b1
  } shunt_mode_e;

endpackage

`default_nettype wire

[hdl/multichannel_current_moving_average_unit.sv]
// ----------------------------------------------------------------------------
// Multichannel current moving average unit
// Per-channel boxcar average of scaled current samples held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one raw current word in tdata and its channel in
// tuser. Each transaction yields exactly one master transaction with the
// channel in tuser and the scaled sample and the average in tdata.
// The user must write the shunt mode register via cfg_we_i and cfg_wdata_i
// only while no transaction is in flight; the block does not enforce this.
// A result is offered from the output register once its input transaction
// has moved through stages s1, s2 and s3. One transaction is taken in every
// cycle while the receiver takes results; the read-modify-write of the window
// RAM and running sum spans two pipeline stages; two multiplier stages follow.
// After reset the running sums, ring positions and fill flags are zero. The
// window RAM is not swept: a per-channel fill flag masks entries that were
// never written, so the block takes input from the first cycle after reset.
// When the receiver stalls, results collect in the pipeline stages and input
// is still taken until every stage holds a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module multichannel_current_moving_average_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // raw_current
  input  logic [cma_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // channel
  input  logic [cma_pkg::CH_W-1:0]           s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // scaled_sample, average, zero fill
  output logic [cma_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // channel_out
  output logic [cma_pkg::CH_W-1:0]           m_axis_tuser
);
  import cma_pkg::*;

  shunt_mode_e mode_q;

  logic [SLOT_W-1:0] slot_q [CHANNELS];
  logic              full_q [CHANNELS];
  logic [SUM_W-1:0]  sum_q  [CHANNELS];

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;

  logic                s_accept;
  logic [CH_IDX_W-1:0] idx0;
  logic                inr0;
  logic [SLOT_W-1:0]   slot0;
  logic [SLOT_W-1:0]   slot_d;
  logic                wrap0;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] sample0;

  logic                v1_q, v2_q, v3_q, vo_q;
  logic                adv1, adv2, adv3;

  logic [CH_W-1:0]     s1_ch_q;
  logic                s1_inr_q;
  logic                s1_old_vld_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [ADDR_W-1:0]   s1_addr_q;
  logic [CH_IDX_W-1:0] idx1;
  logic [SAMPLE_W-1:0] old1;
  logic [SUM_W-1:0]    sum_d;
  logic                wr_en;

  logic [CH_W-1:0]     s2_ch_q;
  logic                s2_inr_q;
  logic [SAMPLE_W-1:0] s2_sample_q;
  logic [SUM_W-1:0]    s2_sum_q;
  logic [SUM_PROD_W-1:0] prod2;

  logic [CH_W-1:0]     s3_ch_q;
  logic                s3_inr_q;
  logic [SAMPLE_W-1:0] s3_sample_q;
  logic [Q_W-1:0]      s3_q_q;
  logic [AVG_PROD_W-1:0] prod3;
  logic [AVG_W-1:0]    avg3;

  logic [CH_W-1:0]     out_ch_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic [AVG_W-1:0]    out_avg_q;

  // Stage handshake: a stage loads when it is empty or its content moves on.
  assign adv3          = !vo_q || m_axis_tready;
  assign adv2          = !v3_q || adv3;
  assign adv1          = !v2_q || adv2;
  assign s_axis_tready = !v1_q || adv1;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign idx0    = CH_IDX_W'(s_axis_tuser);
  assign inr0    = 32'(s_axis_tuser) < 32'(CHANNELS);
  assign slot0   = slot_q[idx0];
  assign wrap0   = slot0 == SLOT_W'(WINDOW - 1);
  assign slot_d  = wrap0 ? '0 : slot0 + SLOT_W'(1);
  assign rd_addr = ADDR_W'(idx0) * ADDR_W'(WINDOW) + ADDR_W'(slot0);

  cma_scale u_scale (
    .raw_i    (s_axis_tdata[RAW_W-1:0]),
    .mode_i   (mode_q),
    .sample_o (sample0)
  );

  assign idx1  = CH_IDX_W'(s1_ch_q);
  assign old1  = s1_old_vld_q ? rd_data_q : '0;
  assign sum_d = sum_q[idx1] - SUM_W'(old1) + SUM_W'(s1_sample_q);
  assign wr_en = v1_q && adv1 && s1_inr_q;

  assign prod2 = SUM_PROD_W'(s2_sum_q) * SUM_PROD_W'(SUM_RECIP);
  assign prod3 = AVG_PROD_W'(s3_q_q) * AVG_PROD_W'(AVG_MUL);
  assign avg3  = s3_inr_q ? AVG_W'(prod3 >> AVG_SHIFT) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= SHUNT_020;
    end else if (cfg_we_i) begin
      mode_q <= shunt_mode_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        slot_q[i] <= '0;
        full_q[i] <= 1'b0;
      end
    end else if (s_accept && inr0) begin
      slot_q[idx0] <= slot_d;
      if (wrap0) begin
        full_q[idx0] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i] <= '0;
      end
    end else if (wr_en) begin
      sum_q[idx1] <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      rd_data_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[s1_addr_q] <= s1_sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        v1_q <= s_axis_tvalid;
      end
      if (adv1) begin
        v2_q <= v1_q;
      end
      if (adv2) begin
        v3_q <= v2_q;
      end
      if (adv3) begin
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_ch_q      <= s_axis_tuser;
      s1_inr_q     <= inr0;
      s1_old_vld_q <= full_q[idx0];
      s1_sample_q  <= sample0;
      s1_addr_q    <= rd_addr;
    end
    if (adv1 && v1_q) begin
      s2_ch_q     <= s1_ch_q;
      s2_inr_q    <= s1_inr_q;
      s2_sample_q <= s1_sample_q;
      s2_sum_q    <= sum_d;
    end
    if (adv2 && v2_q) begin
      s3_ch_q     <= s2_ch_q;
      s3_inr_q    <= s2_inr_q;
      s3_sample_q <= s2_sample_q;
      s3_q_q      <= Q_W'(prod2 >> SUM_SHIFT);
    end
    if (adv3 && v3_q) begin
      out_ch_q     <= s3_ch_q;
      out_sample_q <= s3_sample_q;
      out_avg_q    <= avg3;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tuser  = out_ch_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - SAMPLE_W - AVG_W)'(0), out_avg_q, out_sample_q};

  `ASSERT_NEVER(a_rmw_overlap, clk_i, rst_ni, s_accept && wr_en && (rd_addr == s1_addr_q), "window RAM read and write hit the same entry")
  `ASSERT_PROP(a_slot_range, clk_i, rst_ni, s_accept |-> (slot0 <= SLOT_W'(WINDOW - 1)), "ring position beyond the window")
  `ASSERT_PROP(a_s1_hold, clk_i, rst_ni, (v1_q && !adv1) |=> (v1_q && $stable(s1_addr_q) && $stable(rd_data_q)), "stalled read-modify-write stage lost its operands")

endmodule

`default_nettype wire

[hdl/cma_scale.sv]
// ----------------------------------------------------------------------------
// Current sample scaler
// Masks the sign bit of a raw current word and scales it to tenths of ampere.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cma_scale (
  input  logic [cma_pkg::RAW_W-1:0]    raw_i,
  input  cma_pkg::shunt_mode_e         mode_i,
  output logic [cma_pkg::SAMPLE_W-1:0] sample_o
);
  import cma_pkg::*;

  logic [MAG_W-1:0]        mag;
  logic [SCALE_MUL_W-1:0]  mul;
  logic [SCALE_PROD_W-1:0] prod;

  assign mag  = raw_i[MAG_W-1:0];
  assign mul  = (mode_i == SHUNT_010) ? SCALE_MUL_010 : SCALE_MUL_020;
  assign prod = SCALE_PROD_W'(mag) * SCALE_PROD_W'(mul);

  always_comb begin
    unique case (mode_i)
      SHUNT_010: begin
        sample_o = SAMPLE_W'(prod >> SCALE_SHIFT_010);
      end
      SHUNT_020: begin
        sample_o = SAMPLE_W'(prod >> SCALE_SHIFT_020);
      end
    endcase
  end

endmodule

`default_nettype wire
